FILE: design/avr_pkg.sv
package avr_pkg;

    // pipeline depths of the iterative units
    localparam int SQ_STEPS   = 32;  // one result bit per stage, 64-bit radicand
    localparam int DIV_STEPS  = 31;  // one quotient bit per stage
    localparam int MG_W       = 30;  // normalized axis magnitude width
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    // vector to rotate (sign extended), clamped cosine and zero-axis flag
    typedef struct packed {
        logic [2:0][63:0] a;
        logic [31:0]      c;
        logic             zero;
    } t_side;

    // classified item handed from the front part to the back part
    typedef struct packed {
        t_side                 side;
        logic [2:0][MG_W-1:0]  mg;
        logic [2:0]            bneg;
    } t_job;

    // item state while the axis components are divided
    typedef struct packed {
        t_side       side;
        logic [2:0]  bneg;
        logic [30:0] s;
    } t_mid;

endpackage

FILE: design/axis_angle_vector_rotation_core.sv
// structure: 4 front stages, a queue, then 74 back stages set by the 32-step square root and
//   the 31-step divider
// throughput: one beat per cycle, sustained while the output is not stalled
// reset: i_rst_n synchronous active low, clears all valid flags and the queue
module axis_angle_vector_rotation_core #(
    parameter int COMP_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // ax, ay, az, bx, by, bz (COMP_WIDTH each), cos_angle (32), zero fill to bytes
    input  logic [((6*COMP_WIDTH+32+7)/8)*8-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // rx, ry, rz (COMP_WIDTH each), zero fill to bytes
    output logic [((3*COMP_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    // axis_zero
    output logic                  m_axis_tuser
);

    localparam int OUT_W = ((3 * COMP_WIDTH + 7) / 8) * 8;
    localparam int W     = COMP_WIDTH;

    logic                               in_beat;
    logic                               front_valid;
    avr_pkg::t_job                      front_job;
    logic [2:0]                         front_inflight;
    logic                               q_valid;
    avr_pkg::t_job                      q_job;
    logic [avr_pkg::FIFO_CNT_W-1:0]     q_count;
    logic                               q_pop;
    logic [W-1:0]                       res_x;
    logic [W-1:0]                       res_y;
    logic [W-1:0]                       res_z;

    // credit check: items still in the front stages already own a queue slot
    assign s_axis_tready = (5'(q_count) + 5'(front_inflight)) < 5'(avr_pkg::FIFO_DEPTH);
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // front: sign handling, cosine clamp, zero-axis detect and axis normalization
    avr_front #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_beat),
        .i_ax        (s_axis_tdata[0*W +: W]),
        .i_ay        (s_axis_tdata[1*W +: W]),
        .i_az        (s_axis_tdata[2*W +: W]),
        .i_bx        (s_axis_tdata[3*W +: W]),
        .i_by        (s_axis_tdata[4*W +: W]),
        .i_bz        (s_axis_tdata[5*W +: W]),
        .i_cos_angle (s_axis_tdata[6*W +: 32]),
        .o_valid     (front_valid),
        .o_job       (front_job),
        .o_inflight  (front_inflight)
    );

    // short queue decouples the front from back-pressure on the output
    avr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_job),
        .o_count (q_count)
    );

    // back: square roots, unit axis division, rotation matrix, matrix times vector
    avr_back #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rx    (res_x),
        .o_ry    (res_y),
        .o_rz    (res_z),
        .o_zero  (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_W'({res_z, res_y, res_x});

endmodule

FILE: design/avr_isqrt.sv
module avr_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_val,
    output logic [31:0] o_root
);

    logic [63:0] r_v   [avr_pkg::SQ_STEPS];
    logic [63:0] r_res [avr_pkg::SQ_STEPS];

    for (genvar k = 0; k < avr_pkg::SQ_STEPS; k++) begin : g_st
        localparam logic [63:0] BitK = 64'd1 << (62 - 2 * k);
        logic [63:0] v_in;
        logic [63:0] res_in;
        logic [63:0] trial;

        if (k == 0) begin : g_first
            assign v_in   = i_val;
            assign res_in = '0;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign res_in = r_res[k-1];
        end

        assign trial = res_in + BitK;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (v_in >= trial) begin
                    r_v[k]   <= v_in - trial;
                    r_res[k] <= (res_in >> 1) + BitK;
                end else begin
                    r_v[k]   <= v_in;
                    r_res[k] <= res_in >> 1;
                end
            end
        end
    end

    assign o_root = r_res[avr_pkg::SQ_STEPS-1][31:0];

endmodule

FILE: design/avr_divider.sv
module avr_divider (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [60:0] i_num,
    input  logic [30:0] i_den,
    output logic [30:0] o_quo
);

    logic [60:0] r_rem [avr_pkg::DIV_STEPS];
    logic [30:0] r_den [avr_pkg::DIV_STEPS];
    logic [30:0] r_quo [avr_pkg::DIV_STEPS];

    for (genvar k = 0; k < avr_pkg::DIV_STEPS; k++) begin : g_st
        localparam int QBit = avr_pkg::DIV_STEPS - 1 - k;
        logic [60:0] rem_in;
        logic [30:0] den_in;
        logic [30:0] quo_in;
        logic [60:0] trial;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign trial = 61'(den_in) << QBit;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= den_in;
                if (rem_in >= trial) begin
                    r_rem[k] <= rem_in - trial;
                    r_quo[k] <= quo_in | (31'd1 << QBit);
                end else begin
                    r_rem[k] <= rem_in;
                    r_quo[k] <= quo_in;
                end
            end
        end
    end

    assign o_quo = r_quo[avr_pkg::DIV_STEPS-1];

endmodule

FILE: design/avr_fifo.sv
module avr_fifo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  avr_pkg::t_job                      i_data,
    input  logic                               i_pop,
    output logic                               o_valid,
    output avr_pkg::t_job                      o_data,
    output logic [avr_pkg::FIFO_CNT_W-1:0]     o_count
);

    avr_pkg::t_job                    r_mem [avr_pkg::FIFO_DEPTH];
    logic [avr_pkg::FIFO_PTR_W-1:0]   r_wp;
    logic [avr_pkg::FIFO_PTR_W-1:0]   r_rp;
    logic [avr_pkg::FIFO_CNT_W-1:0]   r_cnt;
    logic                             pop_ok;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && pop_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: design/avr_front.sv
module avr_front #(
    parameter int COMP_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [COMP_WIDTH-1:0] i_ax,
    input  logic [COMP_WIDTH-1:0] i_ay,
    input  logic [COMP_WIDTH-1:0] i_az,
    input  logic [COMP_WIDTH-1:0] i_bx,
    input  logic [COMP_WIDTH-1:0] i_by,
    input  logic [COMP_WIDTH-1:0] i_bz,
    input  logic [31:0]           i_cos_angle,
    output logic                  o_valid,
    output avr_pkg::t_job         o_job,
    output logic [2:0]            o_inflight
);

    localparam int NG    = (COMP_WIDTH + 7) / 8;
    localparam int PAD_W = NG * 8;
    localparam int MSB_W = $clog2(COMP_WIDTH);
    localparam int EXT_W = COMP_WIDTH + avr_pkg::MG_W - 1;

    // stage 1: magnitudes, clamp
    avr_pkg::t_side        r_side1, n_side1;
    logic [COMP_WIDTH-1:0] r_mag1 [3];
    logic [COMP_WIDTH-1:0] n_mag1 [3];
    logic [COMP_WIDTH-1:0] r_or1;
    logic [2:0]            r_bneg1, n_bneg1;
    logic                  r_v1;

    // stage 2: per-byte leading one
    avr_pkg::t_side        r_side2;
    logic [COMP_WIDTH-1:0] r_mag2 [3];
    logic [2:0]            r_bneg2;
    logic [NG-1:0]         r_gnz2, n_gnz2;
    logic [2:0]            r_gmsb2 [NG];
    logic [2:0]            n_gmsb2 [NG];
    logic                  r_v2;

    // stage 3: leading one of the whole word
    avr_pkg::t_side        r_side3;
    logic [COMP_WIDTH-1:0] r_mag3 [3];
    logic [2:0]            r_bneg3;
    logic [MSB_W-1:0]      r_m3, n_m3;
    logic                  r_v3;

    // stage 4: normalize
    avr_pkg::t_job         r_job4, n_job4;
    logic                  r_v4;

    logic [COMP_WIDTH-1:0] b_in [3];
    logic [PAD_W-1:0]      or_pad;

    assign b_in[0] = i_bx;
    assign b_in[1] = i_by;
    assign b_in[2] = i_bz;

    always_comb begin
        logic signed [31:0] c_in;
        c_in = $signed(i_cos_angle);
        n_side1.a[0] = 64'($signed(i_ax));
        n_side1.a[1] = 64'($signed(i_ay));
        n_side1.a[2] = 64'($signed(i_az));
        if (c_in > avr_pkg::ONE_Q30) begin
            n_side1.c = avr_pkg::ONE_Q30;
        end else if (c_in < -avr_pkg::ONE_Q30) begin
            n_side1.c = -avr_pkg::ONE_Q30;
        end else begin
            n_side1.c = c_in;
        end
        for (int i = 0; i < 3; i++) begin
            n_bneg1[i] = b_in[i][COMP_WIDTH-1];
            n_mag1[i]  = n_bneg1[i] ? (~b_in[i] + 1'b1) : b_in[i];
        end
        n_side1.zero = ((i_bx | i_by | i_bz) == '0);
    end

    assign or_pad = PAD_W'(r_or1);

    always_comb begin
        logic [7:0] grp;
        for (int g = 0; g < NG; g++) begin
            grp        = or_pad[g*8 +: 8];
            n_gnz2[g]  = |grp;
            n_gmsb2[g] = '0;
            for (int b = 0; b < 8; b++) begin
                if (grp[b]) begin
                    n_gmsb2[g] = 3'(b);
                end
            end
        end
    end

    always_comb begin
        n_m3 = '0;
        for (int g = 0; g < NG; g++) begin
            if (r_gnz2[g]) begin
                n_m3 = MSB_W'(g * 8 + int'(r_gmsb2[g]));
            end
        end
    end

    // largest magnitude lands in [2^29, 2^30)
    always_comb begin
        logic [EXT_W-1:0] ext;
        n_job4.side = r_side3;
        n_job4.bneg = r_bneg3;
        for (int i = 0; i < 3; i++) begin
            ext            = {r_mag3[i], {(avr_pkg::MG_W - 1){1'b0}}};
            n_job4.mg[i]   = avr_pkg::MG_W'(ext >> r_m3);
        end
    end

    always_ff @(posedge i_clk) begin
        r_side1 <= n_side1;
        r_mag1  <= n_mag1;
        r_or1   <= n_mag1[0] | n_mag1[1] | n_mag1[2];
        r_bneg1 <= n_bneg1;
        r_side2 <= r_side1;
        r_mag2  <= r_mag1;
        r_bneg2 <= r_bneg1;
        r_gnz2  <= n_gnz2;
        r_gmsb2 <= n_gmsb2;
        r_side3 <= r_side2;
        r_mag3  <= r_mag2;
        r_bneg3 <= r_bneg2;
        r_m3    <= n_m3;
        r_job4  <= n_job4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_valid    = r_v4;
    assign o_job      = r_job4;
    assign o_inflight = 3'(r_v1) + 3'(r_v2) + 3'(r_v3) + 3'(r_v4);

endmodule

FILE: design/avr_back.sv
module avr_back #(
    parameter int COMP_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  avr_pkg::t_job         i_job,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COMP_WIDTH-1:0] o_rx,
    output logic [COMP_WIDTH-1:0] o_ry,
    output logic [COMP_WIDTH-1:0] o_rz,
    output logic                  o_zero
);

    localparam int SQ  = avr_pkg::SQ_STEPS;
    localparam int DV  = avr_pkg::DIV_STEPS;
    localparam int MW  = avr_pkg::MG_W;
    localparam int ROT_W = 38;
    localparam int SL_W  = 73;
    localparam int SH_W  = 72;
    localparam int TOT_W = 106;
    localparam int SHF_W = 76;
    localparam logic signed [SHF_W-1:0] SatMax =
        (SHF_W'(1) <<< (COMP_WIDTH - 1)) - SHF_W'(1);
    localparam logic signed [SHF_W-1:0] SatMin = -SatMax - SHF_W'(1);

    logic en;

    // squares
    avr_pkg::t_job      r_j1;
    logic [59:0]        r_sq1 [3];
    logic signed [63:0] r_cc1;
    logic               r_v1;
    // radicands
    avr_pkg::t_job      r_j2;
    logic [63:0]        r_sum2;
    logic [63:0]        r_sv2;
    logic               r_v2;
    // square roots
    avr_pkg::t_job      r_jq [SQ];
    logic [SQ-1:0]      r_vq;
    logic [31:0]        root_len;
    logic [31:0]        root_sin;
    // division setup
    logic [60:0]        r_num3 [3];
    logic [30:0]        r_den3;
    avr_pkg::t_mid      r_m3;
    logic               r_v3;
    // division
    avr_pkg::t_mid      r_md [DV];
    logic [DV-1:0]      r_vd;
    logic [30:0]        quo [3];
    // unit axis
    avr_pkg::t_side     r_side4;
    logic signed [31:0] r_u4 [3];
    logic signed [32:0] r_omc4;
    logic [30:0]        r_s4;
    logic               r_v4;
    // raw products
    avr_pkg::t_side     r_side5;
    logic signed [63:0] r_puu5 [3][3];
    logic signed [63:0] r_psu5 [3];
    logic signed [32:0] r_omc5;
    logic               r_v5;
    // rounded products
    avr_pkg::t_side     r_side6;
    logic signed [33:0] r_m6 [3][3];
    logic signed [33:0] r_su6 [3];
    logic signed [32:0] r_omc6;
    logic               r_v6;
    // scaled by one minus cosine
    avr_pkg::t_side     r_side7;
    logic signed [66:0] r_pr7 [3][3];
    logic signed [33:0] r_su7 [3];
    logic               r_v7;
    // rotation matrix
    avr_pkg::t_side     r_side8;
    logic signed [ROT_W-1:0] r_rot8 [3][3];
    logic signed [ROT_W-1:0] n_rot8 [3][3];
    logic               r_v8;
    // partial products of matrix times vector
    avr_pkg::t_side     r_side9;
    logic signed [70:0] r_pl9 [3][3];
    logic signed [69:0] r_ph9 [3][3];
    logic               r_v9;
    // row sums
    avr_pkg::t_side     r_side10;
    logic signed [SL_W-1:0] r_sl10 [3];
    logic signed [SH_W-1:0] r_sh10 [3];
    logic               r_v10;
    // output register
    logic [COMP_WIDTH-1:0] r_r11 [3];
    logic [COMP_WIDTH-1:0] n_r11 [3];
    logic               r_z11;
    logic               r_v11;

    assign en    = !r_v11 || i_ready;
    assign o_pop = en && i_valid;

    avr_isqrt u_sqrt_len (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r_sum2),
        .o_root (root_len)
    );

    avr_isqrt u_sqrt_sin (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r_sv2),
        .o_root (root_sin)
    );

    for (genvar i = 0; i < 3; i++) begin : g_div
        avr_divider u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_num3[i]),
            .i_den (r_den3),
            .o_quo (quo[i])
        );
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_rot8[i][j] = ROT_W'((r_pr7[i][j] + 67'sd536870912) >>> 30);
                if (i == j) begin
                    n_rot8[i][j] = n_rot8[i][j] + ROT_W'($signed(r_side7.c));
                end
            end
        end
        n_rot8[0][1] = n_rot8[0][1] - ROT_W'(r_su7[2]);
        n_rot8[0][2] = n_rot8[0][2] + ROT_W'(r_su7[1]);
        n_rot8[1][0] = n_rot8[1][0] + ROT_W'(r_su7[2]);
        n_rot8[1][2] = n_rot8[1][2] - ROT_W'(r_su7[0]);
        n_rot8[2][0] = n_rot8[2][0] - ROT_W'(r_su7[1]);
        n_rot8[2][1] = n_rot8[2][1] + ROT_W'(r_su7[0]);
    end

    always_comb begin
        logic signed [TOT_W-1:0] tot;
        logic signed [SHF_W-1:0] shf;
        for (int i = 0; i < 3; i++) begin
            tot = (TOT_W'(r_sh10[i]) <<< 32) + TOT_W'(r_sl10[i]) + TOT_W'(536870912);
            shf = SHF_W'(tot >>> 30);
            if (r_side10.zero) begin
                n_r11[i] = r_side10.a[i][COMP_WIDTH-1:0];
            end else if (shf > SatMax) begin
                n_r11[i] = SatMax[COMP_WIDTH-1:0];
            end else if (shf < SatMin) begin
                n_r11[i] = SatMin[COMP_WIDTH-1:0];
            end else begin
                n_r11[i] = shf[COMP_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_j1 <= i_job;
            for (int i = 0; i < 3; i++) begin
                r_sq1[i] <= 60'(i_job.mg[i]) * 60'(i_job.mg[i]);
            end
            r_cc1 <= 64'($signed(i_job.side.c)) * 64'($signed(i_job.side.c));

            r_j2   <= r_j1;
            r_sum2 <= 64'(r_sq1[0]) + 64'(r_sq1[1]) + 64'(r_sq1[2]);
            r_sv2  <= (64'd1 << 60) - r_cc1;

            r_jq[0] <= r_j2;
            for (int k = 1; k < SQ; k++) begin
                r_jq[k] <= r_jq[k-1];
            end

            for (int i = 0; i < 3; i++) begin
                r_num3[i] <= 61'({r_jq[SQ-1].mg[i], {MW{1'b0}}}) + 61'(root_len[30:1]);
            end
            r_den3    <= root_len[30:0];
            r_m3.side <= r_jq[SQ-1].side;
            r_m3.bneg <= r_jq[SQ-1].bneg;
            r_m3.s    <= root_sin[30:0];

            r_md[0] <= r_m3;
            for (int k = 1; k < DV; k++) begin
                r_md[k] <= r_md[k-1];
            end

            r_side4 <= r_md[DV-1].side;
            for (int i = 0; i < 3; i++) begin
                r_u4[i] <= r_md[DV-1].bneg[i] ? -$signed({1'b0, quo[i]})
                                              :  $signed({1'b0, quo[i]});
            end
            r_omc4 <= 33'(avr_pkg::ONE_Q30) - 33'($signed(r_md[DV-1].side.c));
            r_s4   <= r_md[DV-1].s;

            r_side5 <= r_side4;
            r_omc5  <= r_omc4;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_puu5[i][j] <= 64'(r_u4[i]) * 64'(r_u4[j]);
                end
                r_psu5[i] <= 64'($signed({1'b0, r_s4})) * 64'(r_u4[i]);
            end

            r_side6 <= r_side5;
            r_omc6  <= r_omc5;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_m6[i][j] <= 34'((r_puu5[i][j] + 64'sd536870912) >>> 30);
                end
                r_su6[i] <= 34'((r_psu5[i] + 64'sd536870912) >>> 30);
            end

            r_side7 <= r_side6;
            r_su7   <= r_su6;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pr7[i][j] <= 67'(r_omc6) * 67'(r_m6[i][j]);
                end
            end

            r_side8 <= r_side7;
            r_rot8  <= n_rot8;

            // vector split into an unsigned low word and a signed high word
            r_side9 <= r_side8;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pl9[i][j] <= 71'(r_rot8[i][j])
                                 * 71'($signed({1'b0, r_side8.a[j][31:0]}));
                    r_ph9[i][j] <= 70'(r_rot8[i][j]) * 70'($signed(r_side8.a[j][63:32]));
                end
            end

            r_side10 <= r_side9;
            for (int i = 0; i < 3; i++) begin
                r_sl10[i] <= SL_W'(r_pl9[i][0]) + SL_W'(r_pl9[i][1]) + SL_W'(r_pl9[i][2]);
                r_sh10[i] <= SH_W'(r_ph9[i][0]) + SH_W'(r_ph9[i][1]) + SH_W'(r_ph9[i][2]);
            end

            r_r11 <= n_r11;
            r_z11 <= r_side10.zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_vq  <= '0;
            r_v3  <= 1'b0;
            r_vd  <= '0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_v7  <= 1'b0;
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
            r_v11 <= 1'b0;
        end else if (en) begin
            r_v1  <= i_valid;
            r_v2  <= r_v1;
            r_vq  <= {r_vq[SQ-2:0], r_v2};
            r_v3  <= r_vq[SQ-1];
            r_vd  <= {r_vd[DV-2:0], r_v3};
            r_v4  <= r_vd[DV-1];
            r_v5  <= r_v4;
            r_v6  <= r_v5;
            r_v7  <= r_v6;
            r_v8  <= r_v7;
            r_v9  <= r_v8;
            r_v10 <= r_v9;
            r_v11 <= r_v10;
        end
    end

    assign o_valid = r_v11;
    assign o_rx    = r_r11[0];
    assign o_ry    = r_r11[1];
    assign o_rz    = r_r11[2];
    assign o_zero  = r_z11;

endmodule
